>>> src/dhs_pkg.sv
// Shared types, codes and the sweep program table of the disk head scheduler.
`timescale 1ns / 1ps

package dhs_pkg;

  localparam int CYL_W            = 16;
  localparam int SEEK_W           = 22;
  localparam int DEF_MAX_REQUESTS = 32;

  // Request kinds on the command channel
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLICY   = 2'd0;
  localparam logic [1:0] CFG_SWEEP_UP = 2'd1;
  localparam logic [1:0] CFG_TOP_CYL  = 2'd2;

  localparam logic [CYL_W-1:0] TOP_CYL_RESET = 16'd199;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_SCAN  = 2'd2,
    POL_CSCAN = 2'd3
  } policy_t;

  typedef struct packed {
    policy_t            policy;
    logic               sweep_up;
    logic [CYL_W-1:0]   top_cylinder;
  } cfg_t;

  // One segment of a run: what to emit and over which index range
  typedef enum logic [3:0] {
    OP_DONE,
    OP_FCFS,
    OP_ASC,
    OP_DESC,
    OP_SSTF,
    OP_TOP,
    OP_TOP_IF,
    OP_ZERO,
    OP_ZERO_IF
  } op_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SPLIT,
    SEL_COUNT
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t src_sel;
    sel_t dst_sel;
  } seg_t;

  typedef struct packed {
    logic               vld;
    logic [CYL_W-1:0]   pos;
    logic               end_visit;
    logic [SEEK_W-1:0]  seek;
    logic               fin;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_SPL_RD,
    ST_SPL_CHK,
    ST_SEG,
    ST_RD,
    ST_EMIT,
    ST_FIN
  } state_t;

  // Segment program per policy, direction and phase
  function automatic seg_t seg_of(policy_t pol, logic up, logic [2:0] ph);
    seg_t s;
    s = seg_t'{op: OP_DONE, src_sel: SEL_ZERO, dst_sel: SEL_ZERO};
    case (pol)
      POL_FCFS: begin
        if (ph == 3'd0) s = seg_t'{op: OP_FCFS, src_sel: SEL_ZERO, dst_sel: SEL_COUNT};
      end
      POL_SSTF: begin
        if (ph == 3'd0) s = seg_t'{op: OP_SSTF, src_sel: SEL_SPLIT, dst_sel: SEL_SPLIT};
      end
      POL_SCAN: begin
        case (ph)
          3'd0: s = up ? seg_t'{op: OP_ASC,  src_sel: SEL_SPLIT, dst_sel: SEL_COUNT}
                       : seg_t'{op: OP_DESC, src_sel: SEL_SPLIT, dst_sel: SEL_ZERO};
          3'd1: s = up ? seg_t'{op: OP_TOP_IF,  src_sel: SEL_ZERO, dst_sel: SEL_ZERO}
                       : seg_t'{op: OP_ZERO_IF, src_sel: SEL_ZERO, dst_sel: SEL_ZERO};
          3'd2: s = up ? seg_t'{op: OP_DESC, src_sel: SEL_SPLIT, dst_sel: SEL_ZERO}
                       : seg_t'{op: OP_ASC,  src_sel: SEL_SPLIT, dst_sel: SEL_COUNT};
          default: ;
        endcase
      end
      default: begin
        case (ph)
          3'd0: s = up ? seg_t'{op: OP_ASC,  src_sel: SEL_SPLIT, dst_sel: SEL_COUNT}
                       : seg_t'{op: OP_DESC, src_sel: SEL_SPLIT, dst_sel: SEL_ZERO};
          3'd1: s = up ? seg_t'{op: OP_TOP,  src_sel: SEL_ZERO, dst_sel: SEL_ZERO}
                       : seg_t'{op: OP_ZERO, src_sel: SEL_ZERO, dst_sel: SEL_ZERO};
          3'd2: s = up ? seg_t'{op: OP_ZERO, src_sel: SEL_ZERO, dst_sel: SEL_ZERO}
                       : seg_t'{op: OP_TOP,  src_sel: SEL_ZERO, dst_sel: SEL_ZERO};
          3'd3: s = up ? seg_t'{op: OP_ASC,  src_sel: SEL_ZERO,  dst_sel: SEL_SPLIT}
                       : seg_t'{op: OP_DESC, src_sel: SEL_COUNT, dst_sel: SEL_SPLIT};
          default: ;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

>>> src/dhs_store.sv
// Request memories: arrival order store and sorted store, with registered reads.
`timescale 1ns / 1ps

module dhs_store #(
  parameter int MAX_REQUESTS = dhs_pkg::DEF_MAX_REQUESTS,
  parameter int ADDR_W       = 5
) (
  input  logic                       clk,
  input  logic                       arr_we,
  input  logic [ADDR_W-1:0]          arr_waddr,
  input  logic [dhs_pkg::CYL_W-1:0]  arr_wdata,
  input  logic [ADDR_W-1:0]          arr_raddr,
  output logic [dhs_pkg::CYL_W-1:0]  arr_rdata,
  input  logic                       srt_we,
  input  logic [ADDR_W-1:0]          srt_waddr,
  input  logic [dhs_pkg::CYL_W-1:0]  srt_wdata,
  input  logic [ADDR_W-1:0]          srt_raddr_a,
  input  logic [ADDR_W-1:0]          srt_raddr_b,
  output logic [dhs_pkg::CYL_W-1:0]  srt_rdata_a,
  output logic [dhs_pkg::CYL_W-1:0]  srt_rdata_b
);
  import dhs_pkg::*;

  logic [CYL_W-1:0] arr_mem [MAX_REQUESTS];
  logic [CYL_W-1:0] srt_mem [MAX_REQUESTS];

  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[arr_waddr] <= arr_wdata;
    end
    arr_rdata <= arr_mem[arr_raddr];
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    srt_rdata_a <= srt_mem[srt_raddr_a];
    srt_rdata_b <= srt_mem[srt_raddr_b];
  end

endmodule

>>> src/dhs_ctrl.sv
// Sequencer: sorted insertion on add, split search and segment walk on run.
`timescale 1ns / 1ps

module dhs_ctrl #(
  parameter int MAX_REQUESTS = dhs_pkg::DEF_MAX_REQUESTS,
  parameter int ADDR_W       = 5,
  parameter int CNT_W        = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 req_type,
  input  logic [dhs_pkg::CYL_W-1:0]  cylinder,
  input  dhs_pkg::cfg_t              cfg,
  output logic                       busy,
  output logic                       arr_we,
  output logic [ADDR_W-1:0]          arr_waddr,
  output logic [dhs_pkg::CYL_W-1:0]  arr_wdata,
  output logic [ADDR_W-1:0]          arr_raddr,
  input  logic [dhs_pkg::CYL_W-1:0]  arr_rdata,
  output logic                       srt_we,
  output logic [ADDR_W-1:0]          srt_waddr,
  output logic [dhs_pkg::CYL_W-1:0]  srt_wdata,
  output logic [ADDR_W-1:0]          srt_raddr_a,
  output logic [ADDR_W-1:0]          srt_raddr_b,
  input  logic [dhs_pkg::CYL_W-1:0]  srt_rdata_a,
  input  logic [dhs_pkg::CYL_W-1:0]  srt_rdata_b,
  output dhs_pkg::emit_t             em
);
  import dhs_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   j, j_next;
  logic [CYL_W-1:0]   newv, newv_next;
  logic [CYL_W-1:0]   head, head_next;
  logic [SEEK_W-1:0]  seek, seek_next;
  logic [CNT_W-1:0]   split, split_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]   lim, lim_next;
  logic [2:0]         phase, phase_next;
  op_t                op, op_next;

  seg_t               seg;
  logic [CNT_W-1:0]   src_val, dst_val;
  logic [CNT_W-1:0]   jm1, ptrm1;
  logic               seg_done;
  logic               has_l, has_r, take_left;
  logic [CYL_W-1:0]   dl, dr;
  logic               do_emit, emit_end;
  logic [CYL_W-1:0]   emit_pos, move_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    j     <= j_next;
    newv  <= newv_next;
    head  <= head_next;
    seek  <= seek_next;
    split <= split_next;
    ptr   <= ptr_next;
    lim   <= lim_next;
    phase <= phase_next;
    op    <= op_next;
  end

  assign seg   = seg_of(cfg.policy, cfg.sweep_up, phase);
  assign jm1   = j - 1'b1;
  assign ptrm1 = ptr - 1'b1;

  always_comb begin
    case (seg.src_sel)
      SEL_SPLIT: src_val = split;
      SEL_COUNT: src_val = cnt;
      default:   src_val = '0;
    endcase
    case (seg.dst_sel)
      SEL_SPLIT: dst_val = split;
      SEL_COUNT: dst_val = cnt;
      default:   dst_val = '0;
    endcase
  end

  // Nearest-first picks between the closest unserved entries on each side
  always_comb begin
    has_l     = (ptr != '0);
    has_r     = (lim != cnt);
    dl        = head - srt_rdata_a;
    dr        = srt_rdata_b - head;
    take_left = !has_r || (has_l && (dl <= dr));
    seg_done  = (op == OP_SSTF) ? (!has_l && !has_r) : (ptr == lim);
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    j_next      = j;
    newv_next   = newv;
    head_next   = head;
    seek_next   = seek;
    split_next  = split;
    ptr_next    = ptr;
    lim_next    = lim;
    phase_next  = phase;
    op_next     = op;
    arr_we      = 1'b0;
    arr_waddr   = cnt[ADDR_W-1:0];
    arr_wdata   = cylinder;
    arr_raddr   = ptr[ADDR_W-1:0];
    srt_we      = 1'b0;
    srt_waddr   = j[ADDR_W-1:0];
    srt_wdata   = newv;
    srt_raddr_a = ptr[ADDR_W-1:0];
    srt_raddr_b = lim[ADDR_W-1:0];
    do_emit     = 1'b0;
    emit_end    = 1'b0;
    emit_pos    = '0;
    em          = '0;
    busy        = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_ADD: begin
              if (cnt < MAX_CNT) begin
                arr_we     = 1'b1;
                newv_next  = cylinder;
                j_next     = cnt;
                state_next = ST_INS_RD;
              end
            end
            REQ_RUN: begin
              head_next  = cylinder;
              seek_next  = '0;
              split_next = '0;
              phase_next = '0;
              state_next = ST_SPL_RD;
            end
            REQ_CLEAR: cnt_next = '0;
            default: ;
          endcase
        end
      end
      ST_INS_RD: begin
        if (j == '0) begin
          srt_we     = 1'b1;
          cnt_next   = cnt + 1'b1;
          state_next = ST_IDLE;
        end else begin
          srt_raddr_a = jm1[ADDR_W-1:0];
          state_next  = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        srt_we = 1'b1;
        if (srt_rdata_a > newv) begin
          srt_wdata  = srt_rdata_a;
          j_next     = jm1;
          state_next = ST_INS_RD;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SPL_RD: begin
        if (split == cnt) begin
          state_next = ST_SEG;
        end else begin
          srt_raddr_a = split[ADDR_W-1:0];
          state_next  = ST_SPL_CHK;
        end
      end
      ST_SPL_CHK: begin
        if (srt_rdata_a < head) begin
          split_next = split + 1'b1;
          state_next = ST_SPL_RD;
        end else begin
          state_next = ST_SEG;
        end
      end
      ST_SEG: begin
        op_next  = seg.op;
        ptr_next = src_val;
        lim_next = dst_val;
        case (seg.op)
          OP_DONE: state_next = ST_FIN;
          OP_TOP, OP_TOP_IF: begin
            do_emit    = (seg.op == OP_TOP) || (head < cfg.top_cylinder);
            emit_end   = 1'b1;
            emit_pos   = cfg.top_cylinder;
            phase_next = phase + 1'b1;
          end
          OP_ZERO, OP_ZERO_IF: begin
            do_emit    = (seg.op == OP_ZERO) || (head != '0);
            emit_end   = 1'b1;
            phase_next = phase + 1'b1;
          end
          default: state_next = ST_RD;
        endcase
      end
      ST_RD: begin
        if (seg_done) begin
          phase_next = phase + 1'b1;
          state_next = ST_SEG;
        end else begin
          if (op == OP_DESC || op == OP_SSTF) begin
            srt_raddr_a = ptrm1[ADDR_W-1:0];
          end
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        do_emit    = 1'b1;
        state_next = ST_RD;
        case (op)
          OP_FCFS: begin
            emit_pos = arr_rdata;
            ptr_next = ptr + 1'b1;
          end
          OP_ASC: begin
            emit_pos = srt_rdata_a;
            ptr_next = ptr + 1'b1;
          end
          OP_DESC: begin
            emit_pos = srt_rdata_a;
            ptr_next = ptrm1;
          end
          default: begin
            if (take_left) begin
              emit_pos = srt_rdata_a;
              ptr_next = ptrm1;
            end else begin
              emit_pos = srt_rdata_b;
              lim_next = lim + 1'b1;
            end
          end
        endcase
      end
      ST_FIN: begin
        em.fin     = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    move_len = (emit_pos > head) ? (emit_pos - head) : (head - emit_pos);
    if (do_emit) begin
      seek_next    = seek + SEEK_W'(move_len);
      head_next    = emit_pos;
      em.vld       = 1'b1;
      em.pos       = emit_pos;
      em.end_visit = emit_end;
      em.seek      = seek_next;
    end
  end

endmodule

>>> src/dhs_out.sv
// Result stage: hold one result back so the final one of a run carries last.
`timescale 1ns / 1ps

module dhs_out (
  input  logic                        clk,
  input  logic                        rst,
  input  dhs_pkg::emit_t              em,
  output logic                        result_valid,
  output logic [dhs_pkg::CYL_W-1:0]   position,
  output logic                        is_end_visit,
  output logic [dhs_pkg::SEEK_W-1:0]  seek_total,
  output logic                        last
);
  import dhs_pkg::*;

  logic               pend_vld;
  logic [CYL_W-1:0]   pend_pos;
  logic               pend_end;
  logic [SEEK_W-1:0]  pend_seek;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= pend_vld && (em.vld || em.fin);
      if (em.vld) begin
        pend_vld <= 1'b1;
      end else if (em.fin) begin
        pend_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em.vld || em.fin) begin
      position     <= pend_pos;
      is_end_visit <= pend_end;
      seek_total   <= pend_seek;
      last         <= !em.vld;
    end
    if (em.vld) begin
      pend_pos  <= em.pos;
      pend_end  <= em.end_visit;
      pend_seek <= em.seek;
    end
  end

endmodule

>>> src/disk_head_scheduler.sv
// Top level of the disk head scheduler: configuration registers and block wiring.
`timescale 1ns / 1ps

// Disk head scheduler.
// Command channel: drive start with req_type and cylinder; the request is taken
// at an edge where start is high and busy is low. An add stores a cylinder (it is
// dropped once MAX_REQUESTS are held), a clear empties the queue, a run replays
// the queue from the head position given in cylinder under the configured policy.
// Results leave on position / is_end_visit / seek_total / last, each for exactly
// one cycle marked by result_valid; last flags the final result of a run. The
// receiver cannot hold results off, so nothing here waits on it.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while busy is low and no result is still pending.
// An add inserts in sorted order, moving each larger entry up one place. A run
// first scans the sorted memory for the head's place, then emits each request
// and each sweep end visit in turn; all of it is paced by the registered read
// of the request memories.
// Each result waits in the output stage until the next move or the end of the
// run is known; the last result is on the ports in the first cycle busy is low.
// Reset: queue empty, policy FCFS, sweep up, top cylinder 199. Memory contents
// are not cleared; only entries below the fill count are ever read.
module disk_head_scheduler #(
  parameter int MAX_REQUESTS = dhs_pkg::DEF_MAX_REQUESTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [dhs_pkg::CYL_W-1:0]   cylinder,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [dhs_pkg::CYL_W-1:0]   cfg_data,
  output logic                        result_valid,
  output logic [dhs_pkg::CYL_W-1:0]   position,
  output logic                        is_end_visit,
  output logic [dhs_pkg::SEEK_W-1:0]  seek_total,
  output logic                        last
);
  import dhs_pkg::*;

  // Address covers the store depth; the count must also hold the depth itself
  localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);

  cfg_t               cfg;
  emit_t              em;

  logic               arr_we;
  logic [ADDR_W-1:0]  arr_waddr, arr_raddr;
  logic [CYL_W-1:0]   arr_wdata, arr_rdata;
  logic               srt_we;
  logic [ADDR_W-1:0]  srt_waddr, srt_raddr_a, srt_raddr_b;
  logic [CYL_W-1:0]   srt_wdata, srt_rdata_a, srt_rdata_b;

  // Configuration is accepted every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy       <= POL_FCFS;
      cfg.sweep_up     <= 1'b1;
      cfg.top_cylinder <= TOP_CYL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLICY:   cfg.policy       <= policy_t'(cfg_data[1:0]);
        CFG_SWEEP_UP: cfg.sweep_up     <= cfg_data[0];
        CFG_TOP_CYL:  cfg.top_cylinder <= cfg_data;
        default: ;  // index outside the register list: drop the write
      endcase
    end
  end

  // Arrival store (FCFS order) and sorted store
  dhs_store #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .ADDR_W       (ADDR_W)
  ) u_store (
    .clk         (clk),
    .arr_we      (arr_we),
    .arr_waddr   (arr_waddr),
    .arr_wdata   (arr_wdata),
    .arr_raddr   (arr_raddr),
    .arr_rdata   (arr_rdata),
    .srt_we      (srt_we),
    .srt_waddr   (srt_waddr),
    .srt_wdata   (srt_wdata),
    .srt_raddr_a (srt_raddr_a),
    .srt_raddr_b (srt_raddr_b),
    .srt_rdata_a (srt_rdata_a),
    .srt_rdata_b (srt_rdata_b)
  );

  // Sequencer: insertion on add, split search and sweep segments on run
  dhs_ctrl #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .ADDR_W       (ADDR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .cylinder    (cylinder),
    .cfg         (cfg),
    .busy        (busy),
    .arr_we      (arr_we),
    .arr_waddr   (arr_waddr),
    .arr_wdata   (arr_wdata),
    .arr_raddr   (arr_raddr),
    .arr_rdata   (arr_rdata),
    .srt_we      (srt_we),
    .srt_waddr   (srt_waddr),
    .srt_wdata   (srt_wdata),
    .srt_raddr_a (srt_raddr_a),
    .srt_raddr_b (srt_raddr_b),
    .srt_rdata_a (srt_rdata_a),
    .srt_rdata_b (srt_rdata_b),
    .em          (em)
  );

  // Hold each result back until the next one so the final one can be flagged
  dhs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .em           (em),
    .result_valid (result_valid),
    .position     (position),
    .is_end_visit (is_end_visit),
    .seek_total   (seek_total),
    .last         (last)
  );

endmodule

>>> dv/tb_disk_head_scheduler.sv
// Self-checking testbench for the disk head scheduler: visit order and seek totals.
`timescale 1ns / 1ps

module tb_disk_head_scheduler;
  import dhs_pkg::*;

  localparam int          HALF_PERIOD    = 5;
  localparam int          DEPTH          = DEF_MAX_REQUESTS;
  localparam int          ITEM_TARGET    = 420;
  // An add may walk the whole sorted store before busy drops; wait that out.
  localparam int          SETTLE_CYCLES  = 80;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TAIL_CYCLES    = 40;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;

  // One head move as the block reports it
  typedef struct packed {
    logic [CYL_W-1:0]  pos;
    logic              end_visit;
    logic [SEEK_W-1:0] seek;
    logic              fin;
  } visit_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        req_type;
  logic [CYL_W-1:0]  cylinder;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [CYL_W-1:0]  cfg_data;
  logic              result_valid;
  logic [CYL_W-1:0]  position;
  logic              is_end_visit;
  logic [SEEK_W-1:0] seek_total;
  logic              last;

  disk_head_scheduler #(.MAX_REQUESTS(DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .cylinder     (cylinder),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .position     (position),
    .is_end_visit (is_end_visit),
    .seek_total   (seek_total),
    .last         (last)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: its own copy of the queue and of the three registers.
  // ---------------------------------------------------------------------------
  policy_t          cfg_pol;
  logic             cfg_up;
  logic [CYL_W-1:0] cfg_top;
  logic [CYL_W-1:0] req_store [DEPTH];
  int               req_count;
  int               head_now;
  int               seek_acc;

  // Head moves still owed by the block, oldest first
  visit_t           pending_visits [$];

  int               mismatch_count;
  int               items_sent;
  int               idle_cycles;
  bit               gaps_on;

  // Move the shadow head to pos and queue the move it implies.
  function automatic void add_visit(input int pos, input logic endv);
    visit_t v;
    seek_acc += (pos > head_now) ? pos - head_now : head_now - pos;
    head_now    = pos;
    v.pos       = pos[CYL_W-1:0];
    v.end_visit = endv;
    v.seek      = seek_acc[SEEK_W-1:0];
    v.fin       = 1'b0;
    pending_visits.push_back(v);
  endfunction

  // Work out the full visit order of a run starting at head position head0.
  function automatic void predict_run(input logic [CYL_W-1:0] head0);
    int     sorted_cyl [DEPTH];
    bit     served [DEPTH];
    int     n, split, i, j, c, lo, hi, pick, val, top, base;
    bit     has_lo, has_hi;
    visit_t v;
    n        = req_count;
    top      = cfg_top;
    base     = pending_visits.size();
    head_now = head0;
    seek_acc = 0;
    split    = 0;
    for (i = 0; i < DEPTH; i++) served[i] = 1'b0;
    // Keep arrival order for FCFS; every other policy works on the sorted copy.
    for (i = 0; i < n; i++) begin
      val = req_store[i];
      j = i;
      while (j > 0 && sorted_cyl[j-1] > val) begin
        sorted_cyl[j] = sorted_cyl[j-1];
        j--;
      end
      sorted_cyl[j] = val;
    end
    while (split < n && sorted_cyl[split] < head0) split++;

    case (cfg_pol)
      POL_FCFS: begin
        for (i = 0; i < n; i++) add_visit(req_store[i], 1'b0);
      end
      POL_SSTF: begin
        for (c = 0; c < n; c++) begin
          has_lo = 1'b0;
          has_hi = 1'b0;
          lo = 0;
          hi = 0;
          // Nearest unserved below the head, and nearest at or above it
          for (i = 0; i < n; i++)
            if (!served[i] && sorted_cyl[i] < head_now) begin
              lo = i;
              has_lo = 1'b1;
            end
          for (i = n - 1; i >= 0; i--)
            if (!served[i] && sorted_cyl[i] >= head_now) begin
              hi = i;
              has_hi = 1'b1;
            end
          if (!has_lo) pick = hi;
          else if (!has_hi) pick = lo;
          // Equal distance goes to the lower cylinder
          else pick = (head_now - sorted_cyl[lo] <= sorted_cyl[hi] - head_now) ? lo : hi;
          served[pick] = 1'b1;
          add_visit(sorted_cyl[pick], 1'b0);
        end
      end
      POL_SCAN: begin
        if (cfg_up) begin
          for (i = split; i < n; i++) add_visit(sorted_cyl[i], 1'b0);
          if (head_now < top) add_visit(top, 1'b1);
          for (i = split; i > 0; i--) add_visit(sorted_cyl[i-1], 1'b0);
        end else begin
          for (i = split; i > 0; i--) add_visit(sorted_cyl[i-1], 1'b0);
          if (head_now > 0) add_visit(0, 1'b1);
          for (i = split; i < n; i++) add_visit(sorted_cyl[i], 1'b0);
        end
      end
      default: begin
        // Circular scan: both ends are always visited, the wrap is a full stroke
        if (cfg_up) begin
          for (i = split; i < n; i++) add_visit(sorted_cyl[i], 1'b0);
          add_visit(top, 1'b1);
          add_visit(0, 1'b1);
          for (i = 0; i < split; i++) add_visit(sorted_cyl[i], 1'b0);
        end else begin
          for (i = split; i > 0; i--) add_visit(sorted_cyl[i-1], 1'b0);
          add_visit(0, 1'b1);
          add_visit(top, 1'b1);
          for (i = n; i > split; i--) add_visit(sorted_cyl[i-1], 1'b0);
        end
      end
    endcase

    if (pending_visits.size() > base) begin
      v = pending_visits[pending_visits.size()-1];
      v.fin = 1'b1;
      pending_visits[pending_visits.size()-1] = v;
    end
  endfunction

  // Apply one request to the shadow queue.
  function automatic void apply_request(input logic [1:0] kind, input logic [CYL_W-1:0] cyl);
    case (kind)
      REQ_ADD: begin
        // Drop the add once the store is full
        if (req_count < DEPTH) begin
          req_store[req_count] = cyl;
          req_count++;
        end
      end
      REQ_CLEAR: req_count = 0;
      REQ_RUN:   predict_run(cyl);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driving side. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the block takes it. busy cannot move
  // between a falling edge and the next rising edge, so a request raised while
  // busy is low is taken at that rising edge, and is predicted right here.
  task automatic send_request(input logic [1:0] kind, input logic [CYL_W-1:0] cyl);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    cylinder <= cyl;
    apply_request(kind, cyl);
    if (kind != REQ_UNUSED) items_sent++;
    @(posedge clk);
  endtask

  // Drop start, then wait until every owed visit is out and an add in flight
  // has finished its sorted insert.
  task automatic settle_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_visits.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CYL_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLICY:   cfg_pol = policy_t'(data[1:0]);
      CFG_SWEEP_UP: cfg_up  = data[0];
      CFG_TOP_CYL:  cfg_top = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Cylinder with weight on both ends of the disk and on the sweep end.
  function automatic logic [CYL_W-1:0] pick_cylinder();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return cfg_top;
      2:       return '1;
      3, 4:    return CYL_W'($urandom_range(0, 65535));
      default: return CYL_W'($urandom_range(0, cfg_top));
    endcase
  endfunction

  function automatic logic [CYL_W-1:0] pick_top();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return TOP_CYL_RESET;
      3:       return CYL_W'($urandom_range(2, 1000));
      default: return CYL_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: FCFS, sweep up, top 199, empty queue.
  task automatic test_reset_defaults();
    send_request(REQ_RUN, 16'd100);
    send_request(REQ_ADD, 16'd0);
    send_request(REQ_ADD, 16'hFFFF);
    send_request(REQ_ADD, 16'd150);
    send_request(REQ_RUN, 16'd100);
  endtask

  // SSTF, and SCAN and C-SCAN in both directions, on a queue of 0, 50, 150 and 65535.
  task automatic test_policies_directed();
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_SSTF));
    // Head at 100 sits halfway between 50 and 150: the lower one wins
    send_request(REQ_ADD, 16'd50);
    send_request(REQ_RUN, 16'd100);
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_SCAN));
    // Going up the head passes 65535, above the end, so no end visit
    send_request(REQ_RUN, 16'd100);
    settle_idle();
    write_register(CFG_SWEEP_UP, 16'd0);
    send_request(REQ_RUN, 16'd100);
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_CSCAN));
    write_register(CFG_TOP_CYL, 16'd1);
    send_request(REQ_RUN, 16'd100);
    settle_idle();
    // Requests above a top of 1: the end visit moves the head downward
    write_register(CFG_SWEEP_UP, 16'd1);
    send_request(REQ_RUN, 16'd100);
    settle_idle();
    // An index with no register behind it changes nothing
    write_register(CFG_UNUSED, 16'hFFFF);
    write_register(CFG_TOP_CYL, 16'hFFFF);
    send_request(REQ_RUN, 16'hFFFF);
  endtask

  // Empty runs, head already at the sweep end, and the unused request kind.
  task automatic test_empty_runs_and_noise();
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_SCAN));
    write_register(CFG_TOP_CYL, TOP_CYL_RESET);
    send_request(REQ_CLEAR, 16'hFFFF);
    send_request(REQ_RUN, TOP_CYL_RESET);
    send_request(REQ_RUN, 16'd20);
    settle_idle();
    write_register(CFG_SWEEP_UP, 16'd0);
    send_request(REQ_RUN, 16'd0);
    send_request(REQ_RUN, 16'd20);
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_CSCAN));
    send_request(REQ_RUN, 16'd77);
    send_request(REQ_UNUSED, 16'hFFFF);
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_SSTF));
    send_request(REQ_RUN, 16'd5);
    send_request(REQ_ADD, 16'd7);
    send_request(REQ_RUN, 16'd3);
  endtask

  // Fill past capacity; the extra adds must be dropped.
  task automatic test_store_overflow();
    int i;
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_FCFS));
    write_register(CFG_SWEEP_UP, 16'd1);
    write_register(CFG_TOP_CYL, 16'd999);
    send_request(REQ_CLEAR, 16'd0);
    for (i = 0; i < DEPTH + 2; i++) send_request(REQ_ADD, pick_cylinder());
    send_request(REQ_RUN, pick_cylinder());
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_CSCAN));
    send_request(REQ_RUN, pick_cylinder());
    settle_idle();
    write_register(CFG_POLICY, 16'(POL_SSTF));
    send_request(REQ_RUN, pick_cylinder());
  endtask

  // Phases of random settings, each with several load-and-run sequences.
  task automatic test_random_workloads();
    int seq, nseq, n, i, runs, shape;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      // Close the run with no gaps at all
      if (items_sent > ITEM_TARGET * 85 / 100) gaps_on = 1'b0;
      write_register(CFG_POLICY, CYL_W'($urandom_range(0, 65535)));
      write_register(CFG_SWEEP_UP, CYL_W'($urandom_range(0, 65535)));
      write_register(CFG_TOP_CYL, pick_top());
      nseq = $urandom_range(3, 6);
      for (seq = 0; seq < nseq; seq++) begin
        shape = $urandom_range(0, 9);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH + 2) : $urandom_range(0, 8);
        runs = $urandom_range(1, 2);
        // Mostly a fresh queue; sometimes append to what is held, or only clear
        if (shape < 7 || shape == 9) send_request(REQ_CLEAR, CYL_W'($urandom_range(0, 65535)));
        if (shape != 9)
          for (i = 0; i < n; i++) begin
            if (shape == 8 && $urandom_range(0, 2) == 0)
              send_request(REQ_UNUSED, CYL_W'($urandom_range(0, 65535)));
            send_request(REQ_ADD, pick_cylinder());
          end
        for (i = 0; i < runs; i++) send_request(REQ_RUN, pick_cylinder());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: compare each strobed visit with the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    visit_t want;
    if (!rst && result_valid) begin
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected visit: pos %0d end %0b seek %0d last %0b",
                                  position, is_end_visit, seek_total, last));
      end else begin
        want = pending_visits.pop_front();
        if (position !== want.pos || is_end_visit !== want.end_visit ||
            seek_total !== want.seek || last !== want.fin)
          report_mismatch($sformatf(
            "visit mismatch: expected pos %0d end %0b seek %0d last %0b, got %0d %0b %0d %0b",
            want.pos, want.end_visit, want.seek, want.fin,
            position, is_end_visit, seek_total, last));
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    req_type       = REQ_ADD;
    cylinder       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_POLICY;
    cfg_data       = '0;
    cfg_pol        = POL_FCFS;
    cfg_up         = 1'b1;
    cfg_top        = TOP_CYL_RESET;
    req_count      = 0;
    head_now       = 0;
    seek_acc       = 0;
    mismatch_count = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    gaps_on        = 1'b1;

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_policies_directed();
    test_empty_runs_and_noise();
    test_store_overflow();
    test_random_workloads();

    // Drain every owed visit, then give the block time to show anything extra
    @(negedge clk);
    start <= 1'b0;
    while (pending_visits.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
